[design/zcgs_pkg.sv]
// Package for the zero-crossing gain switch.
// Holds the transaction structs, operation and sign codes, the channel state entry
// and the volume-to-gain table. No dependencies.
package zcgs_pkg;

  localparam int MaxChans   = 6;
  localparam int SampleBits = 24;
  localparam int ChanBits   = 3;
  localparam int VolBits    = 7;
  localparam int GainBits   = 17;
  localparam int GainShift  = 16;
  localparam int ProdBits   = SampleBits + GainBits + 1;
  localparam int VolMax     = 100;
  localparam int GainDiv    = 10000;
  localparam int GainRound  = 5000;
  localparam int TableDepth = 1 << VolBits;

  localparam logic [GainBits-1:0] UnityGain  = GainBits'(1 << GainShift);
  localparam logic [ChanBits-1:0] CountReset = ChanBits'(2);
  localparam logic [ChanBits-1:0] CountMax   = ChanBits'(MaxChans);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_VOLUME = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SIGN_UNSET = 2'd0,
    SIGN_POS   = 2'd1,
    SIGN_NEG   = 2'd2
  } sign_t;

  typedef struct packed {
    logic [1:0]                   operation;
    logic [ChanBits-1:0]          channel;
    logic signed [SampleBits-1:0] sample_in;
    logic [VolBits-1:0]           volume_level;
  } in_data_t;

  typedef struct packed {
    logic [ChanBits-1:0]          channel_out;
    logic signed [SampleBits-1:0] sample_out;
  } out_data_t;

  typedef struct packed {
    logic [GainBits-1:0] active;
    logic [GainBits-1:0] pending;
    sign_t               ref_sign;
  } entry_t;

  localparam entry_t ResetEntry = '{active: UnityGain, pending: UnityGain,
                                    ref_sign: SIGN_UNSET};

  typedef logic [GainBits-1:0] gain_table_t [TableDepth];

  // (v/100)^2 in Q1.16, rounded half up; codes above 100 are never used
  function automatic gain_table_t build_gain_table();
    gain_table_t t;
    for (int v = 0; v < TableDepth; v++) begin
      if (v <= VolMax) begin
        t[v] = GainBits'((v * v * (1 << GainShift) + GainRound) / GainDiv);
      end else begin
        t[v] = '0;
      end
    end
    return t;
  endfunction

  localparam gain_table_t GainTable = build_gain_table();

endpackage

[design/zero_crossing_gain_switch.sv]
// Zero-crossing gain switch: per-channel gain stage, top level.
// Input passes through the stage 1 registers to the output register; one per cycle unless out_ready stalls it.
// Channel state sits in a 6-entry synchronous memory: read at accept, modified and
// written back when stage 1 advances, with forwarding for back-to-back hits on one channel.
// Reset (sync, active low) clears per-entry valid bits so every entry reads as unity
// gain with no reference sign; no clearing pass. Channel count resets to 2.
module zero_crossing_gain_switch (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  zcgs_pkg::in_data_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output zcgs_pkg::out_data_t       out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CB = zcgs_pkg::ChanBits;
  localparam int GB = zcgs_pkg::GainBits;
  localparam int SB = zcgs_pkg::SampleBits;
  localparam int PB = zcgs_pkg::ProdBits;
  localparam int MC = zcgs_pkg::MaxChans;

  // configuration
  logic [CB-1:0] chan_count_r;
  logic [CB-1:0] eff_count;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= zcgs_pkg::CountReset;
    end else if (cfg_wr) begin
      chan_count_r <= cfg_pwdata[CB-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (!cfg_paddr[2]) begin
      cfg_prdata[CB-1:0] = chan_count_r;
    end
  end

  always_comb begin
    if (chan_count_r == '0) begin
      eff_count = CB'(1);
    end else if (chan_count_r > zcgs_pkg::CountMax) begin
      eff_count = zcgs_pkg::CountMax;
    end else begin
      eff_count = chan_count_r;
    end
  end

  // stage 0 decode
  logic in_accept;
  logic in_chan_ok;
  logic in_act;

  assign in_accept  = in_valid && in_ready;
  assign in_chan_ok = in_data.channel < eff_count;

  always_comb begin
    case (in_data.operation)
      zcgs_pkg::OP_SAMPLE: in_act = in_chan_ok;
      zcgs_pkg::OP_VOLUME: in_act = in_chan_ok &&
                                    (in_data.volume_level <= zcgs_pkg::VolBits'(zcgs_pkg::VolMax));
      zcgs_pkg::OP_COMMIT: in_act = 1'b1;
      default:             in_act = 1'b0;
    endcase
  end

  // stage 1 registers
  logic                 s1_valid_r;
  logic                 s1_act_r;
  logic [1:0]           s1_op_r;
  logic [CB-1:0]        s1_ch_r;
  logic signed [SB-1:0] s1_sample_r;
  logic [GB-1:0]        s1_pgain_r;

  // state memory and its bookkeeping
  zcgs_pkg::entry_t mem [MC];
  zcgs_pkg::entry_t rd_r;
  logic [MC-1:0]    valid_r;
  logic [MC-1:0]    commit_r;
  logic             fwd_hit_r;
  logic [CB-1:0]    fwd_ch_r;
  zcgs_pkg::entry_t fwd_entry_r;

  logic             s1_go;
  logic             s1_out;
  logic             wr_en;
  zcgs_pkg::entry_t raw;
  zcgs_pkg::entry_t cur;
  zcgs_pkg::entry_t new_entry;
  logic [GB-1:0]    out_gain;
  logic signed [PB-1:0] prod;

  logic                 out_valid_r;
  zcgs_pkg::out_data_t  out_data_r;

  assign s1_out   = s1_act_r && (s1_op_r == zcgs_pkg::OP_SAMPLE);
  assign s1_go    = s1_valid_r && (!s1_out || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign wr_en    = s1_go && s1_act_r && (s1_op_r != zcgs_pkg::OP_COMMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r    <= in_act;
      s1_op_r     <= in_data.operation;
      s1_ch_r     <= in_data.channel;
      s1_sample_r <= in_data.sample_in;
      s1_pgain_r  <= zcgs_pkg::GainTable[in_data.volume_level];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_chan_ok) begin
      rd_r <= mem[in_data.channel];
    end
    if (wr_en) begin
      mem[s1_ch_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_accept) begin
      fwd_hit_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_ch_r    <= s1_ch_r;
      fwd_entry_r <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      commit_r <= '0;
    end else if (s1_go && s1_act_r) begin
      if (s1_op_r == zcgs_pkg::OP_COMMIT) begin
        commit_r <= '1;
      end else begin
        valid_r[s1_ch_r]  <= 1'b1;
        commit_r[s1_ch_r] <= 1'b0;
      end
    end
  end

  // current entry: forwarded write, then reset and pending-commit views
  always_comb begin
    raw = (fwd_hit_r && (fwd_ch_r == s1_ch_r)) ? fwd_entry_r : rd_r;
    if (!valid_r[s1_ch_r]) begin
      cur = zcgs_pkg::ResetEntry;
    end else if (commit_r[s1_ch_r]) begin
      cur = '{active: raw.pending, pending: raw.pending, ref_sign: zcgs_pkg::SIGN_UNSET};
    end else begin
      cur = raw;
    end
  end

  always_comb begin
    logic           is_zero;
    zcgs_pkg::sign_t sg;
    zcgs_pkg::sign_t ref1;
    logic           differ;
    logic           sw;
    is_zero   = (s1_sample_r == '0);
    sg        = (!s1_sample_r[SB-1] && !is_zero) ? zcgs_pkg::SIGN_POS : zcgs_pkg::SIGN_NEG;
    ref1      = (cur.ref_sign == zcgs_pkg::SIGN_UNSET) ? sg : cur.ref_sign;
    differ    = (cur.pending != cur.active);
    sw        = differ && ((sg != ref1) || is_zero);
    new_entry = cur;
    case (s1_op_r)
      zcgs_pkg::OP_VOLUME: begin
        new_entry.pending  = s1_pgain_r;
        new_entry.ref_sign = zcgs_pkg::SIGN_UNSET;
      end
      zcgs_pkg::OP_SAMPLE: begin
        if (sw) begin
          new_entry.active   = cur.pending;
          new_entry.ref_sign = zcgs_pkg::SIGN_UNSET;
        end else if (differ) begin
          new_entry.ref_sign = ref1;
        end
      end
      default: begin
        new_entry = cur;
      end
    endcase
  end

  assign out_gain = new_entry.active;
  assign prod = PB'(s1_sample_r) * $signed({1'b0, out_gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_out) begin
      out_data_r.channel_out <= s1_ch_r;
      out_data_r.sample_out  <= prod[zcgs_pkg::GainShift +: SB];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/zcgs_checker.sv]
// Port-level checker for the zero-crossing gain switch, bound to the top level.
// Depends on zcgs_pkg and zero_crossing_gain_switch.
module zcgs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input zcgs_pkg::out_data_t out_data,
  input logic                cfg_pready
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_out_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.channel_out < zcgs_pkg::CountMax)
    else $error("result channel out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

  // a result needs an earlier accepted input transaction or a held result
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!out_ready))
    else $error("result without source transaction");

endmodule

bind zero_crossing_gain_switch zcgs_checker u_zcgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_pready(cfg_pready)
);
